### hw/rtl/fsl_pkg.sv
package fsl_pkg;

    localparam int PATTERN_MAX = 32;
    localparam int LINE_MAX    = 1024;
    localparam int FILL_W      = $clog2(LINE_MAX);
    localparam int LEN_W       = 10;
    localparam int CNT_W       = 32;
    localparam int CFG_W       = 64;
    localparam int CFG_IDX_W   = 3;
    localparam int PLEN_W      = 6;
    localparam int PAT_WORDS   = 4;
    localparam int QUEUE_DEPTH = 3;
    localparam int QCNT_W      = 2;
    localparam int PUSH_W      = 2;

    localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WORD0   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WORD1   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WORD2   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WORD3   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INVERT  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_QUIET   = 3'd7;

    localparam logic       KIND_LINE    = 1'b0;
    localparam logic       KIND_SUMMARY = 1'b1;
    localparam logic [7:0] NEWLINE      = 8'h0A;

    typedef struct packed {
        logic             kind;
        logic             sel;
        logic [CNT_W-1:0] idx;
        logic [LEN_W-1:0] len;
        logic             app;
        logic [CNT_W-1:0] cnt;
        logic             exit_code;
        logic             last;
    } t_record;

    typedef struct packed {
        logic shift;
        logic clear;
    } t_cell_ctrl;

endpackage

### hw/rtl/fsl_cell.sv
module fsl_cell
    import fsl_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell_ctrl i_ctrl,
    input  logic [7:0] i_byte,
    input  logic       i_live,
    input  logic       i_active,
    input  logic [7:0] i_pat_byte,
    output logic [7:0] o_byte,
    output logic       o_live,
    output logic       o_ok
);

    logic [7:0] r_byte;
    logic       r_live;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_byte <= i_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live <= 1'b0;
        end else if (i_ctrl.clear) begin
            r_live <= 1'b0;
        end else if (i_ctrl.shift) begin
            r_live <= i_live;
        end
    end

    // compare the byte this cell takes on the shift
    assign o_ok   = !i_active || (i_live && (i_byte == i_pat_byte));
    assign o_byte = r_byte;
    assign o_live = r_live;

endmodule

### hw/rtl/fsl_out_queue.sv
module fsl_out_queue
    import fsl_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [PUSH_W-1:0] i_push_n,
    input  t_record           i_rec0,
    input  t_record           i_rec1,
    input  logic              i_stall,
    output logic              o_valid,
    output t_record           o_rec,
    output logic              o_busy
);

    t_record           r_entry [QUEUE_DEPTH];
    t_record           n_entry [QUEUE_DEPTH];
    logic [QCNT_W-1:0] r_count;
    logic [QCNT_W-1:0] n_count;
    logic [QCNT_W-1:0] cnt_pop;
    logic              pop;

    assign pop     = (r_count != '0) && !i_stall;
    assign cnt_pop = r_count - QCNT_W'(pop);

    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (pop && (i < QUEUE_DEPTH - 1)) begin
                n_entry[i] = r_entry[i+1];
            end else begin
                n_entry[i] = r_entry[i];
            end
            if ((i_push_n != '0) && (QCNT_W'(i) == cnt_pop)) begin
                n_entry[i] = i_rec0;
            end
            if ((i_push_n == PUSH_W'(2)) && (QCNT_W'(i) == cnt_pop + QCNT_W'(1))) begin
                n_entry[i] = i_rec1;
            end
        end
        n_count = cnt_pop + QCNT_W'(i_push_n);
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            r_entry[i] <= n_entry[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_rec   = r_entry[0];
    // keep room for the two records an end of stream can give
    assign o_busy  = (r_count > QCNT_W'(1));

endmodule

### hw/rtl/fixed_string_line_filter.sv
// A request's records are registered in the output queue before they reach the output.
// One byte per cycle while o_stall is low; an end of stream gives up to two records.
// The window is a row of byte cells that shift one step per kept byte.
// Reset is synchronous and active low: configuration clears to zero, line
// numbering restarts at one and the output queue empties.
module fixed_string_line_filter
    import fsl_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_end_of_stream,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic                 o_record_kind,
    output logic                 o_line_selected,
    output logic [CNT_W-1:0]     o_line_index,
    output logic [LEN_W-1:0]     o_stored_length,
    output logic                 o_append_newline,
    output logic [CNT_W-1:0]     o_selected_count,
    output logic                 o_exit_code,
    output logic                 o_last_record
);

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    logic [PLEN_W-1:0]              r_pat_len;
    logic [PAT_WORDS-1:0][CFG_W-1:0] r_pat_word;
    logic                           r_invert;
    logic                           r_count_mode;
    logic                           r_quiet;

    logic              r_found;
    logic [FILL_W-1:0] r_fill;
    logic              r_last_nl;
    logic [CNT_W-1:0]  r_line;
    logic [CNT_W-1:0]  r_hits;
    logic              r_stopped;

    logic [PAT_WORDS*CFG_W-1:0] pat_flat;
    logic [PLEN_W-1:0]          ulen;
    logic                       accept;
    logic                       work;
    logic                       keep;
    logic                       hit;
    t_cell_ctrl                 cell_ctrl;
    logic [7:0]                 cell_byte [PATTERN_MAX];
    logic                       cell_live [PATTERN_MAX];
    logic [PATTERN_MAX-1:0]     cell_ok;

    logic [FILL_W-1:0]       fill_c;
    logic                    found_c;
    logic                    last_c;
    logic                    close;
    logic                    sel;
    logic [CNT_W-1:0]        hits_next;
    logic                    quiet_stop;
    logic                    line_rec;
    logic                    summary;
    logic [FILL_W+LEN_W-1:0] fill_wide;
    t_record                 rec_line;
    t_record                 rec_sum;
    t_record                 rec0;
    logic [PUSH_W-1:0]       push_n;
    t_record                 out_rec;
    logic                    q_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_len    <= '0;
            r_pat_word   <= '0;
            r_invert     <= 1'b0;
            r_count_mode <= 1'b0;
            r_quiet      <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_PAT_LEN: r_pat_len     <= i_cfg_data[PLEN_W-1:0];
                REG_WORD0:   r_pat_word[0] <= i_cfg_data;
                REG_WORD1:   r_pat_word[1] <= i_cfg_data;
                REG_WORD2:   r_pat_word[2] <= i_cfg_data;
                REG_WORD3:   r_pat_word[3] <= i_cfg_data;
                REG_INVERT:  r_invert      <= i_cfg_data[0];
                REG_COUNT:   r_count_mode  <= i_cfg_data[0];
                REG_QUIET:   r_quiet       <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign pat_flat = r_pat_word;
    assign ulen     = ({{(32-PLEN_W){1'b0}}, r_pat_len} > 32'(PATTERN_MAX))
                    ? PLEN_W'(PATTERN_MAX) : r_pat_len;

    assign accept = i_valid && !o_stall;
    assign work   = accept && !r_stopped;
    assign keep   = (r_fill < FILL_W'(LINE_MAX - 1));

    assign cell_ctrl.shift = work && !i_end_of_stream && keep;
    assign cell_ctrl.clear = work && !i_end_of_stream && (i_data_byte == NEWLINE);

    for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cell
        logic [PLEN_W-1:0] pos;
        logic              active;
        logic [7:0]        pat_byte;
        logic [7:0]        in_byte;
        logic              in_live;

        // cell j takes the byte that must equal pattern byte ulen-1-j
        assign pos      = ulen - PLEN_W'(1) - PLEN_W'(j);
        assign active   = (PLEN_W'(j) < ulen);
        assign pat_byte = pos[PLEN_W-1] ? 8'h00 : pat_flat[{pos[4:0], 3'b000} +: 8];

        if (j == 0) begin : g_head
            assign in_byte = i_data_byte;
            assign in_live = 1'b1;
        end else begin : g_link
            assign in_byte = cell_byte[j-1];
            assign in_live = cell_live[j-1];
        end

        fsl_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctrl     (cell_ctrl),
            .i_byte     (in_byte),
            .i_live     (in_live),
            .i_active   (active),
            .i_pat_byte (pat_byte),
            .o_byte     (cell_byte[j]),
            .o_live     (cell_live[j]),
            .o_ok       (cell_ok[j])
        );
    end

    assign hit = (ulen != '0) && (&cell_ok);

    always_comb begin
        if (i_end_of_stream) begin
            fill_c  = r_fill;
            found_c = r_found;
            last_c  = r_last_nl;
            close   = (r_fill != '0);
        end else begin
            fill_c  = r_fill + FILL_W'(keep);
            found_c = r_found || (keep && hit);
            last_c  = keep ? (i_data_byte == NEWLINE) : r_last_nl;
            close   = (i_data_byte == NEWLINE);
        end
        sel        = ((ulen == '0) || found_c) ^ r_invert;
        hits_next  = (close && sel && (r_hits != CNT_MAX)) ? r_hits + CNT_W'(1) : r_hits;
        quiet_stop = close && sel && r_quiet;
        line_rec   = close && !r_count_mode && !r_quiet;
        summary    = quiet_stop || i_end_of_stream;
    end

    assign fill_wide = {{LEN_W{1'b0}}, fill_c};

    always_comb begin
        rec_line.kind      = KIND_LINE;
        rec_line.sel       = sel;
        rec_line.idx       = r_line;
        rec_line.len       = fill_wide[LEN_W-1:0];
        rec_line.app       = (fill_c == '0) || !last_c;
        rec_line.cnt       = hits_next;
        rec_line.exit_code = 1'b0;
        rec_line.last      = 1'b0;

        rec_sum.kind      = KIND_SUMMARY;
        rec_sum.sel       = 1'b0;
        rec_sum.idx       = '0;
        rec_sum.len       = '0;
        rec_sum.app       = 1'b0;
        rec_sum.cnt       = hits_next;
        rec_sum.exit_code = (hits_next == '0);
        rec_sum.last      = 1'b1;

        rec0   = line_rec ? rec_line : rec_sum;
        push_n = work ? (PUSH_W'(line_rec) + PUSH_W'(summary)) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found   <= 1'b0;
            r_fill    <= '0;
            r_last_nl <= 1'b0;
            r_line    <= CNT_W'(1);
            r_hits    <= '0;
            r_stopped <= 1'b0;
        end else if (work) begin
            r_hits <= hits_next;
            if (summary) begin
                r_stopped <= 1'b1;
            end
            if (close && !quiet_stop) begin
                r_found   <= 1'b0;
                r_fill    <= '0;
                r_last_nl <= 1'b0;
                if (r_line != CNT_MAX) begin
                    r_line <= r_line + CNT_W'(1);
                end
            end else if (!i_end_of_stream) begin
                r_found   <= found_c;
                r_fill    <= fill_c;
                r_last_nl <= last_c;
            end
        end
    end

    fsl_out_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_n (push_n),
        .i_rec0   (rec0),
        .i_rec1   (rec_sum),
        .i_stall  (i_stall),
        .o_valid  (o_valid),
        .o_rec    (out_rec),
        .o_busy   (q_busy)
    );

    assign o_stall          = q_busy;
    assign o_record_kind    = out_rec.kind;
    assign o_line_selected  = out_rec.sel;
    assign o_line_index     = out_rec.idx;
    assign o_stored_length  = out_rec.len;
    assign o_append_newline = out_rec.app;
    assign o_selected_count = out_rec.cnt;
    assign o_exit_code      = out_rec.exit_code;
    assign o_last_record    = out_rec.last;

`ifndef SYNTH
    a_stop_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stopped |=> r_stopped)
        else $error("stream end flag dropped");

    a_no_push_stopped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stopped |-> (push_n == '0))
        else $error("record produced after stream end");

    a_summary_stopped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_record_kind == KIND_SUMMARY)) |-> r_stopped)
        else $error("summary shown before stream end");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(LINE_MAX - 1))
        else $error("line fill beyond limit");
`endif

endmodule
